// ----- rtl/wpp_pkg.sv -----
// Package for the waveform peak pyramid: sizing constants and the
// transaction types shared by the top level and its checker, and the entry type.
// No dependencies.
package wpp_pkg;

    localparam int LEVELS       = 16;
    localparam int INDEX_BITS   = 24;
    localparam int SAMPLE_BITS  = 24;
    localparam int PEAK_TOP     = 254;
    localparam int GROUP_FRAMES = 4;

    localparam int LEV_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PH_W  = $clog2(GROUP_FRAMES);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          start_req;
    } t_in;

    typedef struct packed {
        logic [3:0]  level;
        logic [23:0] index;
        logic [7:0]  peak_left;
        logic [7:0]  peak_right;
        logic [7:0]  mean_left;
        logic [7:0]  mean_right;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0] peak_l;
        logic [7:0] peak_r;
        logic [7:0] mean_l;
        logic [7:0] mean_r;
    } t_entry;

endpackage

// ----- rtl/waveform_peak_pyramid.sv -----
// Top level of the waveform peak pyramid: group peak detection, level
// cascade sequencer and a shared bit-serial integer square root.
// Depends on wpp_pkg.

// Each stereo frame is one input transaction. A frame that does not close a
// group of four leaves the block in its idle state, ready for the next frame.
// A frame that closes a group passes through a byte state that forms the
// level-0 bytes, then one emit state per produced entry (held as long as the
// sink stalls), and for every level that pairs up two passes through the
// shared square-root unit, one for the left mean and one for the right, each
// a square-and-halve step followed by eight root digits.
// The input is not ready while entries are being produced, and at most one
// result transaction is offered at a time, lowest level first, with last set
// on the final entry the frame produced. start_req clears the whole pyramid
// before its frame is taken.
module waveform_peak_pyramid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wpp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wpp_pkg::t_out o_data
);
    import wpp_pkg::*;

    localparam int ROOT_STEPS = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_EMIT,
        S_SQ,
        S_ROOT
    } t_state;

    t_state                 r_state;
    logic [PH_W-1:0]        r_phase;
    logic [SAMPLE_BITS-1:0] r_max_l;
    logic [SAMPLE_BITS-1:0] r_max_r;
    t_entry                 r_pend [LEVELS];
    logic [LEVELS-1:0]      r_pvalid;
    logic [INDEX_BITS-1:0]  r_count [LEVELS];
    logic [LEV_W-1:0]       r_lev;
    t_entry                 r_entry;
    t_entry                 r_pa;
    logic                   r_ch;
    logic [7:0]             r_mean_l;
    logic [15:0]            r_x;
    logic [11:0]            r_rem;
    logic [7:0]             r_root;
    logic [2:0]             r_step;

    // Magnitudes of the incoming samples; the most negative code maps to 2^(N-1).
    logic [SAMPLE_BITS-1:0] mag_l, mag_r;
    logic [PH_W-1:0]        eff_phase;
    logic [SAMPLE_BITS-1:0] n_max_l, n_max_r;

    always_comb begin
        mag_l     = i_data.left_sample[SAMPLE_BITS-1] ?
                    SAMPLE_BITS'(-i_data.left_sample) : SAMPLE_BITS'(i_data.left_sample);
        mag_r     = i_data.right_sample[SAMPLE_BITS-1] ?
                    SAMPLE_BITS'(-i_data.right_sample) : SAMPLE_BITS'(i_data.right_sample);
        eff_phase = i_data.start_req ? '0 : r_phase;
        if (eff_phase == '0) begin
            n_max_l = mag_l;
            n_max_r = mag_r;
        end else begin
            n_max_l = (mag_l > r_max_l) ? mag_l : r_max_l;
            n_max_r = (mag_r > r_max_r) ? mag_r : r_max_r;
        end
    end

    // Byte scaling: mag * 254 as (mag << 8) - (mag << 1), then drop SAMPLE_BITS-1 bits.
    logic [SAMPLE_BITS+7:0] prod_l, prod_r;
    logic [8:0]             scl_l, scl_r;
    logic [7:0]             byte_l, byte_r;

    always_comb begin
        prod_l = {r_max_l, 8'd0} - {7'd0, r_max_l, 1'b0};
        prod_r = {r_max_r, 8'd0} - {7'd0, r_max_r, 1'b0};
        scl_l  = prod_l[SAMPLE_BITS+7:SAMPLE_BITS-1];
        scl_r  = prod_r[SAMPLE_BITS+7:SAMPLE_BITS-1];
        byte_l = (scl_l > 9'(PEAK_TOP)) ? 8'(PEAK_TOP) : scl_l[7:0];
        byte_r = (scl_r > 9'(PEAK_TOP)) ? 8'(PEAK_TOP) : scl_r[7:0];
    end

    // Square and halve for the channel under work: (a*a + b*b) / 2.
    logic [7:0]  sq_a, sq_b;
    logic [16:0] sq_sum;

    always_comb begin
        sq_a   = r_ch ? r_pa.mean_r : r_pa.mean_l;
        sq_b   = r_ch ? r_entry.mean_r : r_entry.mean_l;
        sq_sum = 17'(sq_a * sq_a) + 17'(sq_b * sq_b);
    end

    // One digit of the restoring square root per cycle.
    logic [11:0] rem_sh, trial, n_rem;
    logic        root_ge;
    logic [7:0]  n_root;

    always_comb begin
        rem_sh  = {r_rem[9:0], r_x[15:14]};
        trial   = {2'b00, r_root, 2'b01};
        root_ge = (rem_sh >= trial);
        n_rem   = root_ge ? (rem_sh - trial) : rem_sh;
        n_root  = {r_root[6:0], root_ge};
    end

    logic top_lev, emit_last;
    assign top_lev   = (r_lev == LEV_W'(LEVELS - 1));
    assign emit_last = top_lev || !r_pvalid[r_lev];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    always_comb begin
        o_data.level      = 4'(r_lev);
        o_data.index      = 24'(r_count[r_lev]);
        o_data.peak_left  = r_entry.peak_l;
        o_data.peak_right = r_entry.peak_r;
        o_data.mean_left  = r_entry.mean_l;
        o_data.mean_right = r_entry.mean_r;
        o_data.last       = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_max_l  <= '0;
            r_max_r  <= '0;
            r_pvalid <= '0;
            r_lev    <= '0;
            r_ch     <= 1'b0;
            r_step   <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data.start_req) begin
                            r_pvalid <= '0;
                            for (int i = 0; i < LEVELS; i++) begin
                                r_count[i] <= '0;
                            end
                        end
                        r_max_l <= n_max_l;
                        r_max_r <= n_max_r;
                        r_phase <= PH_W'(eff_phase + 1'b1);
                        if (eff_phase == PH_W'(GROUP_FRAMES - 1)) begin
                            r_state <= S_BYTE;
                        end
                    end
                end
                S_BYTE: begin
                    r_entry <= '{peak_l: byte_l, peak_r: byte_r,
                                 mean_l: byte_l, mean_r: byte_r};
                    r_lev   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_count[r_lev] <= r_count[r_lev] + 1'b1;
                        if (top_lev) begin
                            r_state <= S_IDLE;
                        end else if (r_pvalid[r_lev]) begin
                            r_pa            <= r_pend[r_lev];
                            r_pvalid[r_lev] <= 1'b0;
                            r_ch            <= 1'b0;
                            r_state         <= S_SQ;
                        end else begin
                            r_pend[r_lev]   <= r_entry;
                            r_pvalid[r_lev] <= 1'b1;
                            r_state         <= S_IDLE;
                        end
                    end
                end
                S_SQ: begin
                    r_x     <= sq_sum[16:1];
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_x    <= {r_x[13:0], 2'b00};
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'(ROOT_STEPS - 1)) begin
                        if (!r_ch) begin
                            r_mean_l <= n_root;
                            r_ch     <= 1'b1;
                            r_state  <= S_SQ;
                        end else begin
                            r_entry.peak_l <= (r_pa.peak_l > r_entry.peak_l) ?
                                              r_pa.peak_l : r_entry.peak_l;
                            r_entry.peak_r <= (r_pa.peak_r > r_entry.peak_r) ?
                                              r_pa.peak_r : r_entry.peak_r;
                            r_entry.mean_l <= r_mean_l;
                            r_entry.mean_r <= n_root;
                            r_lev          <= r_lev + 1'b1;
                            r_state        <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/wpp_checker.sv -----
// Port-level checker for the waveform peak pyramid and its bind statement.
// Depends on wpp_pkg and the top level waveform_peak_pyramid.
module wpp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input wpp_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input wpp_pkg::t_out o_data
);
    import wpp_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // The block never takes a frame while it offers a result.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    // More entries follow a result without last, so no frame is taken next.
    a_cascade_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last |=> !o_ready)
        else $error("input ready in the middle of a cascade");

    // After the final entry of a frame the block is ready for the next frame.
    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last |=> o_ready)
        else $error("block not ready after the last entry");

    // Peak bytes stay within PEAK_TOP, and a mean never exceeds the peak of the same channel.
    a_mean_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.peak_left <= 8'(PEAK_TOP) && o_data.peak_right <= 8'(PEAK_TOP)
                 && o_data.mean_left <= o_data.peak_left
                 && o_data.mean_right <= o_data.peak_right)
        else $error("mean byte above peak byte");

endmodule

bind waveform_peak_pyramid wpp_checker u_wpp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ----- dv/wpp_pyramid_monitor.sv -----
// Monitor for the waveform peak pyramid: predicts the overview entries of
// every accepted frame, compares each accepted entry field by field, counts
// mismatches. Depends on wpp_pkg.
`timescale 1ns / 100ps

module wpp_pyramid_monitor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  wpp_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  wpp_pkg::t_out i_out_data,
    output int            o_mismatches,
    output int            o_outstanding
);
    import wpp_pkg::*;

    t_out                   entries_due[$];
    t_entry                 held_entry [LEVELS];
    logic                   held_valid [LEVELS];
    logic [INDEX_BITS-1:0]  entry_count [LEVELS];
    logic [PH_W-1:0]        group_phase;
    logic [SAMPLE_BITS-1:0] group_peak_l;
    logic [SAMPLE_BITS-1:0] group_peak_r;
    int                     mismatches = 0;
    int                     outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] abs_sample(
        input logic [SAMPLE_BITS-1:0] s);
        // The most negative sample maps onto 2^(SAMPLE_BITS-1), which still fits.
        return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
    endfunction

    function automatic logic [7:0] scale_to_byte(input logic [SAMPLE_BITS-1:0] mag);
        longint scaled;
        scaled = (longint'(mag) * PEAK_TOP) >>> (SAMPLE_BITS - 1);
        return (scaled > PEAK_TOP) ? 8'(PEAK_TOP) : scaled[7:0];
    endfunction

    function automatic logic [7:0] rms_byte(input logic [7:0] a, input logic [7:0] b);
        int sq;
        int root;
        int trial;
        sq   = (int'(a) * int'(a) + int'(b) * int'(b)) / 2;
        root = 0;
        for (int k = 7; k >= 0; k--) begin
            trial = root | (1 << k);
            if (trial * trial <= sq) root = trial;
        end
        return root[7:0];
    endfunction

    function automatic t_entry merge_pair(input t_entry a, input t_entry b);
        t_entry m;
        m.peak_l = (a.peak_l > b.peak_l) ? a.peak_l : b.peak_l;
        m.peak_r = (a.peak_r > b.peak_r) ? a.peak_r : b.peak_r;
        m.mean_l = rms_byte(a.mean_l, b.mean_l);
        m.mean_r = rms_byte(a.mean_r, b.mean_r);
        return m;
    endfunction

    task automatic clear_pyramid();
        group_phase  = '0;
        group_peak_l = '0;
        group_peak_r = '0;
        for (int lev = 0; lev < LEVELS; lev++) begin
            held_entry[lev]  = '0;
            held_valid[lev]  = 1'b0;
            entry_count[lev] = '0;
        end
    endtask

    // Folds one frame into the pyramid and queues every entry it completes.
    task automatic fold_frame(input t_in frame);
        logic [SAMPLE_BITS-1:0] mag_l;
        logic [SAMPLE_BITS-1:0] mag_r;
        t_entry                 cur;
        t_out                   res;
        logic                   closes;
        if (frame.start_req) clear_pyramid();
        mag_l = abs_sample(frame.left_sample);
        mag_r = abs_sample(frame.right_sample);
        if (group_phase == '0) begin
            group_peak_l = mag_l;
            group_peak_r = mag_r;
        end else begin
            if (mag_l > group_peak_l) group_peak_l = mag_l;
            if (mag_r > group_peak_r) group_peak_r = mag_r;
        end
        group_phase = group_phase + 1'b1;
        if (group_phase != '0) return;

        cur.peak_l = scale_to_byte(group_peak_l);
        cur.peak_r = scale_to_byte(group_peak_r);
        cur.mean_l = cur.peak_l;
        cur.mean_r = cur.peak_r;
        for (int lev = 0; lev < LEVELS; lev++) begin
            res.level      = lev[3:0];
            res.index      = entry_count[lev][23:0];
            res.peak_left  = cur.peak_l;
            res.peak_right = cur.peak_r;
            res.mean_left  = cur.mean_l;
            res.mean_right = cur.mean_r;
            entry_count[lev] = entry_count[lev] + 1'b1;
            // The top level never waits for a partner.
            closes = (lev == LEVELS - 1) || !held_valid[lev];
            if (!closes) begin
                cur = merge_pair(held_entry[lev], cur);
                held_valid[lev] = 1'b0;
            end else if (lev < LEVELS - 1) begin
                held_entry[lev] = cur;
                held_valid[lev] = 1'b1;
            end
            res.last = closes;
            entries_due.push_back(res);
            if (closes) break;
        end
    endtask

    always @(posedge i_clk) begin
        t_out due;
        if (!i_rst_n) begin
            clear_pyramid();
            entries_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) fold_frame(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (entries_due.size() == 0) begin
                    report_mismatch("entry with none due, level", 0, i_out_data.level);
                end else begin
                    due = entries_due.pop_front();
                    if (i_out_data.level !== due.level)
                        report_mismatch("level", due.level, i_out_data.level);
                    if (i_out_data.index !== due.index)
                        report_mismatch("index", due.index, i_out_data.index);
                    if (i_out_data.peak_left !== due.peak_left)
                        report_mismatch("peak_left", due.peak_left, i_out_data.peak_left);
                    if (i_out_data.peak_right !== due.peak_right)
                        report_mismatch("peak_right", due.peak_right, i_out_data.peak_right);
                    if (i_out_data.mean_left !== due.mean_left)
                        report_mismatch("mean_left", due.mean_left, i_out_data.mean_left);
                    if (i_out_data.mean_right !== due.mean_right)
                        report_mismatch("mean_right", due.mean_right, i_out_data.mean_right);
                    if (i_out_data.last !== due.last)
                        report_mismatch("last", due.last, i_out_data.last);
                end
            end
        end
        outstanding = entries_due.size();
    end

endmodule

// ----- dv/waveform_peak_pyramid_tb.sv -----
// Testbench top for the waveform peak pyramid: clock, reset, frame stimulus
// and sink stalls; checking is done by wpp_pyramid_monitor.
// Depends on wpp_pkg, waveform_peak_pyramid and wpp_pyramid_monitor.
`timescale 1ns / 100ps

module waveform_peak_pyramid_tb;
    import wpp_pkg::*;

    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 320;
    localparam longint CYCLE_LIMIT  = 6_000_000;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_in    i_data;
    logic   o_valid;
    logic   i_ready;
    t_out   o_data;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   hold_req;
    int     mismatches;
    int     outstanding;
    longint cycles = 0;

    waveform_peak_pyramid u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    wpp_pyramid_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sink side: random stalls, plus one long hold-off when requested.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in make_frame(input int l, input int r, input bit start);
        t_in f;
        f.left_sample  = l[SAMPLE_BITS-1:0];
        f.right_sample = r[SAMPLE_BITS-1:0];
        f.start_req    = start;
        return f;
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(5))
            0:       return -(1 << (SAMPLE_BITS - 1));
            1:       return (1 << (SAMPLE_BITS - 1)) - 1;
            2:       return int'($urandom_range(80000)) - 40000;
            3:       return int'($urandom_range(6)) - 3;
            default: return int'($urandom);
        endcase
    endfunction

    // Called at a clock edge; returns at the edge where the frame is taken.
    task automatic send_frame(input t_in frame);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= frame;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_frame(make_frame(rand_sample(), rand_sample(), $urandom_range(49) == 0));
    endtask

    // Stops offering frames until every predicted entry has been taken.
    task automatic drain_entries();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_data        <= '0;
        hold_req      = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 72;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full-scale values of both signs, including the most negative sample.
        send_frame(make_frame(8388607, -8388608, 1'b1));
        send_frame(make_frame(0, 0, 1'b0));
        send_frame(make_frame(-1, 1, 1'b0));
        send_frame(make_frame(4194304, -4194304, 1'b0));
        send_frame(make_frame(-8388608, 8388607, 1'b0));
        send_frame(make_frame(0, 0, 1'b0));
        send_frame(make_frame(1, -1, 1'b0));
        send_frame(make_frame(-4194305, 4194305, 1'b0));
        for (int n = 0; n < 4; n++)
            send_frame(make_frame(0, 0, 1'b0));
        // Magnitudes just either side of the first nonzero byte.
        send_frame(make_frame(33027, -33026, 1'b0));
        send_frame(make_frame(-33026, 33027, 1'b0));
        send_frame(make_frame(100, -100, 1'b0));
        send_frame(make_frame(0, 0, 1'b0));
        // A partial group followed by a restart that must discard it.
        send_frame(make_frame(100000, -100000, 1'b0));
        send_frame(make_frame(-100000, 100000, 1'b0));
        send_frame(make_frame(-8388608, -8388608, 1'b1));
        send_frame(make_frame(1, -1, 1'b0));
        send_frame(make_frame(2, 3, 1'b0));
        send_frame(make_frame(0, 0, 1'b0));

        send_random(120);

        send_idle_pct = 72;
        recv_idle_pct = 14;
        send_random(120);
        drain_entries();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        send_random(40);
        send_random(120);

        drain_entries();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
